### rtl/kcpd_pkg.sv
// Package: shared constants, types and helpers for the clock packet decoder.
`timescale 1ns / 1ps
package kcpd_pkg;

  localparam int unsigned SLOTS     = 6;
  localparam int unsigned LEN_COUNT = 10;

  localparam logic [7:0] HDR_MIN  = 8'd246;
  localparam logic [7:0] HDR_TIME = 8'd252;

  localparam logic [11:0] BASE_2000 = 12'd2000;
  localparam logic [11:0] BASE_1900 = 12'd1900;
  localparam logic [7:0]  MONTH_MAX = 8'd12;

  // Register map, indexed by word
  localparam logic REG_PIVOT = 1'b0;
  localparam logic [6:0] PIVOT_RESET = 7'd80;

  // Payload length per header code, indexed by header minus HDR_MIN
  localparam logic [2:0] LEN_TABLE [LEN_COUNT] = '{
    3'd7, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd6, 3'd2, 3'd1, 3'd1
  };

  typedef logic [SLOTS-1:0][7:0] payload_t;

  typedef struct packed {
    logic     valid;
    payload_t bytes;
  } capture_t;

  typedef struct packed {
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic        month_bad;
    logic        clock_unset;
  } result_t;

  // Packed BCD byte to binary, no digit check: at most 165
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return {4'd0, b[3:0]} + {hi[4:0], 3'd0} + {hi[6:0], 1'b0};
  endfunction

endpackage

### rtl/kcpd_if.sv
// Interfaces: byte input channel and decoded time output channel.
`timescale 1ns / 1ps
interface kcpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface kcpd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  logic        month_bad;
  logic        clock_unset;

  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, output month_bad, output clock_unset,
                  input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, input month_bad, input clock_unset,
                  output ready);
  modport monitor (input valid, input ready, input year, input month, input day,
                   input hour, input minute, input second, input month_bad,
                   input clock_unset);
endinterface

### rtl/keyboard_clock_packet_decoder.sv
// Top level: clock packet decoder with APB configuration and byte/result channels.
// A closed time packet is registered in the capture register, then moved into the result queue.
// Throughput: one byte per cycle; the input stalls only when the capture register and both
// result queue entries are all full.
// Reset (rst, synchronous, active high): idle tracker, empty queue, century_pivot = 80.
// The payload store is not reset; a time packet fills it before it is read.
`timescale 1ns / 1ps
module keyboard_clock_packet_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  kcpd_in_if.sink     din,
  kcpd_out_if.source  dout
);
  import kcpd_pkg::*;

  logic [6:0] pivot;
  logic       cfg_write;
  capture_t   cap;
  result_t    res;
  logic       can_push;
  logic       cap_take;

  // APB register: one word, century_pivot in bits 6:0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot <= PIVOT_RESET;
    end else if (cfg_write && (paddr[2] == REG_PIVOT)) begin
      pivot <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PIVOT) begin
      prdata = {25'd0, pivot};
    end
  end

  // Move a captured packet into the queue whenever there is room
  assign cap_take = cap.valid && can_push;

  kcpd_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .cap_take (cap_take),
    .cap      (cap)
  );

  kcpd_decode u_decode (
    .bytes (cap.bytes),
    .pivot (pivot),
    .res   (res)
  );

  kcpd_out_q u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (cap_take),
    .wdata    (res),
    .can_push (can_push),
    .dout     (dout)
  );

endmodule

### rtl/kcpd_tracker.sv
// Packet tracker: header detection, payload counting and capture of a finished time packet.
`timescale 1ns / 1ps
module kcpd_tracker (
  input  logic               clk,
  input  logic               rst,
  kcpd_in_if.sink            din,
  input  logic               cap_take,
  output kcpd_pkg::capture_t cap
);
  import kcpd_pkg::*;

  logic       in_packet, in_packet_next;
  logic [2:0] bytes_left, bytes_left_next;
  logic       is_time, is_time_next;
  logic [2:0] idx, idx_next;
  logic [7:0] store [SLOTS];
  logic       cap_valid;
  payload_t   cap_bytes;
  logic       accept;
  logic       fire;
  logic [3:0] hdr_off;

  assign din.ready = !cap_valid || cap_take;
  assign accept    = din.valid && din.ready;
  assign hdr_off   = 4'(din.rx_byte - HDR_MIN);
  assign cap.valid = cap_valid;
  assign cap.bytes = cap_bytes;

  always_comb begin
    in_packet_next  = in_packet;
    bytes_left_next = bytes_left;
    is_time_next    = is_time;
    idx_next        = idx;
    fire            = 1'b0;
    if (accept) begin
      if (!in_packet) begin
        if (din.rx_byte >= HDR_MIN) begin
          bytes_left_next = LEN_TABLE[hdr_off];
          is_time_next    = (din.rx_byte == HDR_TIME);
          idx_next        = 3'd0;
          in_packet_next  = 1'b1;
        end
      end else begin
        idx_next        = idx + 3'd1;
        bytes_left_next = bytes_left - 3'd1;
        if (bytes_left == 3'd1) begin
          in_packet_next = 1'b0;
          fire           = is_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      bytes_left <= 3'd0;
      is_time    <= 1'b0;
      idx        <= 3'd0;
      cap_valid  <= 1'b0;
    end else begin
      in_packet  <= in_packet_next;
      bytes_left <= bytes_left_next;
      is_time    <= is_time_next;
      idx        <= idx_next;
      if (fire) begin
        cap_valid <= 1'b1;
      end else if (cap_take) begin
        cap_valid <= 1'b0;
      end
    end
  end

  // Payload store; the seventh byte of the long packet is counted but not kept
  always_ff @(posedge clk) begin
    if (accept && in_packet && (idx < 3'(SLOTS))) begin
      store[idx] <= din.rx_byte;
    end
  end

  // Snapshot the six bytes, merging in the byte that closes the packet
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < SLOTS; i++) begin
        cap_bytes[i] <= (3'(i) == idx) ? din.rx_byte : store[i];
      end
    end
  end

endmodule

### rtl/kcpd_decode.sv
// BCD time decoder: six captured bytes to year, date, time and flags.
`timescale 1ns / 1ps
module kcpd_decode (
  input  kcpd_pkg::payload_t bytes,
  input  logic [6:0]         pivot,
  output kcpd_pkg::result_t  res
);
  import kcpd_pkg::*;

  logic [7:0] yr2;
  logic [7:0] mo;

  assign yr2 = bcd_value(bytes[0]);
  assign mo  = bcd_value(bytes[1]);

  always_comb begin
    res.year        = {4'd0, yr2} + ((yr2 < {1'b0, pivot}) ? BASE_2000 : BASE_1900);
    res.month       = mo;
    res.day         = bcd_value(bytes[2]);
    res.hour        = bcd_value(bytes[3]);
    res.minute      = bcd_value(bytes[4]);
    res.second      = bcd_value(bytes[5]);
    res.month_bad   = (mo == 8'd0) || (mo > MONTH_MAX);
    res.clock_unset = (bytes == '0);
  end

endmodule

### rtl/kcpd_out_q.sv
// Two-entry result queue feeding the output channel.
`timescale 1ns / 1ps
module kcpd_out_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  kcpd_pkg::result_t wdata,
  output logic              can_push,
  kcpd_out_if.source        dout
);
  import kcpd_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  result_t    head;

  assign can_push = (count != 2'd2);
  assign pop      = dout.valid && dout.ready;
  assign head     = mem[rd_ptr];

  assign dout.valid       = (count != 2'd0);
  assign dout.year        = head.year;
  assign dout.month       = head.month;
  assign dout.day         = head.day;
  assign dout.hour        = head.hour;
  assign dout.minute      = head.minute;
  assign dout.second      = head.second;
  assign dout.month_bad   = head.month_bad;
  assign dout.clock_unset = head.clock_unset;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

### rtl/kcpd_chk.sv
// Checker: port-level properties of the decoder output channel, bound to the top level.
`timescale 1ns / 1ps
module kcpd_chk (
  input logic        clk,
  input logic        rst,
  kcpd_out_if.source dout
);

  // Hold an offered result until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.ready |=> dout.valid && $stable(dout.year) && $stable(dout.second))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !dout.valid)
    else $error("result offered right after reset");

  a_month_flag: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.month_bad == ((dout.month == 8'd0) || (dout.month > 8'd12)))
    else $error("month_bad does not match month");

  a_unset_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.clock_unset |-> dout.month == 8'd0 && dout.day == 8'd0 &&
      dout.hour == 8'd0 && dout.minute == 8'd0 && dout.second == 8'd0 &&
      (dout.year == 12'd2000 || dout.year == 12'd1900))
    else $error("unset clock with nonzero fields");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.year >= 12'd1900 && dout.year <= 12'd2165)
    else $error("year out of range");

endmodule

bind keyboard_clock_packet_decoder kcpd_chk u_kcpd_chk (
  .clk  (clk),
  .rst  (rst),
  .dout (dout)
);

### bench/tb.sv
// Testbench: directed and random byte streams through the clock packet decoder, checked live.
`timescale 1ns / 1ps
module tb;
  import kcpd_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int BYTES_PER_RUN  = 150;  // random stream length per pivot setting
  localparam int HOLD_LEN       = 400;  // long sink hold-off, in cycles
  localparam int SETTLE_CYCLES  = 8;    // leave margin before a write
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer anywhere
  localparam logic [2:0] PIVOT_ADDR = {REG_PIVOT, 2'b00};

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kcpd_in_if  din ();
  kcpd_out_if dout ();

  keyboard_clock_packet_decoder u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din     (din),
    .dout    (dout)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stimulus bytes not yet offered, and decoded times still owed by the block
  logic [7:0] rx_stream [$];
  result_t    pending_times [$];

  int err_cnt       = 0;
  int src_gap_pct   = 33;
  int snk_stall_pct = 33;
  bit want_hold     = 1'b0;
  bit byte_taken    = 1'b0;

  // Shadow of the decoder: packet tracker, payload capture and pivot register
  bit             pkt_open    = 1'b0;
  logic [2:0]     pkt_left    = '0;
  bit             pkt_is_time = 1'b0;
  logic [2:0]     pkt_idx     = '0;
  logic [5:0][7:0] pkt_bytes  = '0;
  logic [6:0]     pivot_cfg   = PIVOT_RESET;

  function automatic logic [7:0] bcd2bin(input logic [7:0] b);
    return b[3:0] + 8'd10 * b[7:4];
  endfunction

  // Advance the shadow by one transferred byte; queue a decoded time when a
  // time packet closes.
  task automatic decode_byte(input logic [7:0] b);
    logic [11:0] yr;
    result_t     t;
    if (!pkt_open) begin
      // Bytes below the header range are dropped while idle
      if (b >= HDR_MIN) begin
        pkt_left    = LEN_TABLE[4'(b - HDR_MIN)];
        pkt_is_time = (b == HDR_TIME);
        pkt_idx     = '0;
        pkt_open    = 1'b1;
      end
      return;
    end
    // Any value is payload here, header values included; the seventh byte of
    // the longest packet is counted but not kept
    if (pkt_idx < SLOTS) pkt_bytes[pkt_idx] = b;
    pkt_idx  = pkt_idx + 3'd1;
    pkt_left = pkt_left - 3'd1;
    if (pkt_left != 0) return;
    pkt_open = 1'b0;
    if (!pkt_is_time) return;
    yr = {4'd0, bcd2bin(pkt_bytes[0])};
    // Pivot compares as written, even above 99
    t.year        = (yr < {5'd0, pivot_cfg}) ? yr + BASE_2000 : yr + BASE_1900;
    t.month       = bcd2bin(pkt_bytes[1]);
    t.day         = bcd2bin(pkt_bytes[2]);
    t.hour        = bcd2bin(pkt_bytes[3]);
    t.minute      = bcd2bin(pkt_bytes[4]);
    t.second      = bcd2bin(pkt_bytes[5]);
    t.month_bad   = (t.month < 8'd1) || (t.month > MONTH_MAX);
    t.clock_unset = (pkt_bytes == '0);
    pending_times.push_back(t);
  endtask

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic check_time();
    result_t want;
    if (pending_times.size() == 0) begin
      $error("result transfer with no decoded time pending");
      err_cnt++;
      return;
    end
    want = pending_times.pop_front();
    cmp_field("year",        want.year,        dout.year);
    cmp_field("month",       want.month,       dout.month);
    cmp_field("day",         want.day,         dout.day);
    cmp_field("hour",        want.hour,        dout.hour);
    cmp_field("minute",      want.minute,      dout.minute);
    cmp_field("second",      want.second,      dout.second);
    cmp_field("month_bad",   want.month_bad,   dout.month_bad);
    cmp_field("clock_unset", want.clock_unset, dout.clock_unset);
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    byte_taken <= din.valid && din.ready;
    if (!rst) begin
      if (din.valid && din.ready) decode_byte(din.rx_byte);
      if (dout.valid && dout.ready) check_time();
    end
  end

  // Byte driver: hold the current byte until its transfer, then advance or
  // insert a random gap
  always @(negedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else if (!din.valid || byte_taken) begin
      if (rx_stream.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
        din.rx_byte <= rx_stream.pop_front();
        din.valid   <= 1'b1;
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off once requested
  always @(negedge clk) begin : sink_ctrl
    int hold_cnt;
    if (rst) begin
      hold_cnt = 0;
      dout.ready <= 1'b0;
    end else if (want_hold && hold_cnt < HOLD_LEN) begin
      hold_cnt++;
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready) ||
        (psel && penable && pready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Write the pivot over APB, then read it back
  task automatic set_pivot(input logic [6:0] pv);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PIVOT_ADDR;
    pwdata  <= {25'($urandom), pv};  // upper bits are ignored by the register
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pivot_cfg = pv;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cmp_field("century_pivot", {25'd0, pv}, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Payload byte for a time packet: mostly valid BCD, some raw noise, some extremes
  function automatic logic [7:0] time_field(input int slot);
    int k, m;
    k = $urandom_range(9);
    if (slot == 1 && k < 3) begin
      m = $urandom_range(12, 1);
      return {4'(m / 10), 4'(m % 10)};
    end
    if (k < 6) return {4'($urandom_range(9)), 4'($urandom_range(9))};
    if (k < 9) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'h99;
      2: return 8'hff;
      default: return 8'h9a;
    endcase
  endfunction

  // Append well-formed packets with random content, with idle noise between
  task automatic add_packets(input int n_bytes);
    int         sent, r, len;
    logic [7:0] hdr;
    bit         zero_clk;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      if (r < 10) begin
        rx_stream.push_back(8'($urandom_range(245)));
      end else if (r < 60) begin
        zero_clk = ($urandom_range(19) == 0);
        rx_stream.push_back(HDR_TIME);
        for (int s = 0; s < SLOTS; s++)
          rx_stream.push_back(zero_clk ? 8'h00 : time_field(s));
        sent += 1 + SLOTS;
      end else begin
        hdr = HDR_MIN + 8'($urandom_range(LEN_COUNT - 1));
        len = LEN_TABLE[4'(hdr - HDR_MIN)];
        rx_stream.push_back(hdr);
        for (int s = 0; s < len; s++) rx_stream.push_back(8'($urandom_range(255)));
        sent += 1 + len;
      end
    end
  endtask

  // Wait until every byte has been transferred and every decoded time checked
  task automatic drain();
    do @(posedge clk);
    while (rx_stream.size() != 0 || din.valid || pending_times.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [6:0] pv, input int gap, input int stall,
                           input bit hold);
    set_pivot(pv);
    src_gap_pct   = gap;
    snk_stall_pct = stall;
    if (hold) want_hold = 1'b1;
    add_packets(BYTES_PER_RUN);
    drain();
  endtask

  initial begin
    rst         = 1'b1;
    din.valid   = 1'b0;
    din.rx_byte = '0;
    dout.ready  = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes at the reset pivot of 80:
    // idle bytes just below the header range are dropped
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'd245);
    // unset clock: all zero payload, month 0 flagged bad
    rx_stream.push_back(HDR_TIME);
    repeat (SLOTS) rx_stream.push_back(8'h00);
    // non-digit nibbles everywhere: every payload byte decodes to 165
    rx_stream.push_back(HDR_TIME);
    repeat (SLOTS) rx_stream.push_back(8'hff);
    // year 79 sits just below the pivot; a header value rides as the seconds byte
    rx_stream.push_back(HDR_TIME);
    rx_stream.push_back(8'h79);
    rx_stream.push_back(8'h12);
    rx_stream.push_back(8'h31);
    rx_stream.push_back(8'h23);
    rx_stream.push_back(8'h59);
    rx_stream.push_back(8'hff);
    // one-byte packet carrying a header value as payload
    rx_stream.push_back(8'd254);
    rx_stream.push_back(8'hfc);
    add_packets(BYTES_PER_RUN);
    drain();

    run_phase(7'd0,   33, 33, 1'b0);
    run_phase(7'd99,  0,  0,  1'b0);  // long stretch with no idling on either side
    run_phase(7'd127, 0,  33, 1'b1);  // pivot above any two-digit year; sink holds off, input backs up
    run_phase(7'd1,   33, 33, 1'b0);
    run_phase(7'($urandom_range(99)), 33, 33, 1'b0);
    run_phase(7'($urandom_range(99)), 33, 33, 1'b0);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
